// ----- design/utf8_to_utf16_transcoder_defines.svh -----
// assertion macros for the transcoder rtl
// expects signals named clock and reset in the scope of each use
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// same-cycle implication
`define UTT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/utt_pkg.sv -----
// types and constants of the utf-8 to utf-16 transcoder
// used by utt_decode and utf8_to_utf16_transcoder; no dependencies
package utt_pkg;

   typedef enum logic [2:0] {
      STOP_COMPLETE  = 3'd0,
      STOP_NUL       = 3'd1,
      STOP_BAD_LEAD  = 3'd2,
      STOP_TRUNCATED = 3'd3,
      STOP_FULL      = 3'd4
   } stop_type;

   // register indexes on the csr port
   localparam logic REG_UNIT_CAPACITY    = 1'b0;
   localparam logic REG_REPLACEMENT_CODE = 1'b1;

   localparam logic [15:0] CAPACITY_RESET    = 16'hFFFF;
   localparam logic [15:0] REPLACEMENT_RESET = 16'hFFFD;

   // most results one byte can cause
   localparam int MAX_RES = 3;

   localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
   localparam logic [7:0]  LEAD2_MIN     = 8'd192;
   localparam logic [7:0]  LEAD3_MIN     = 8'd224;
   localparam logic [7:0]  LEAD4_MIN     = 8'd240;
   localparam logic [7:0]  BAD_LEAD_MIN  = 8'd248;
   localparam logic [20:0] CP_2BYTE_MIN  = 21'h00080;
   localparam logic [20:0] CP_3BYTE_MIN  = 21'h00800;
   localparam logic [20:0] CP_4BYTE_MIN  = 21'h10000;
   localparam logic [20:0] CP_MAX        = 21'h10FFFF;
   localparam logic [20:0] SURR_LOW      = 21'h0D800;
   localparam logic [20:0] SURR_HIGH     = 21'h0DFFF;
   localparam logic [15:0] HIGH_SURR     = 16'hD800;
   localparam logic [15:0] LOW_SURR      = 16'hDC00;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_end_marker;
      logic [15:0] units_written;
      logic [2:0]  stop_reason;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [20:0] acc;
      logic [1:0]  remaining;
      logic [2:0]  seq_len;
      logic [15:0] count;
      logic        halted;
      stop_type    reason;
   } state_type;

endpackage

// ----- design/utt_decode.sv -----
// per-byte decode: next string state and up to three results
// depends on utt_pkg
module utt_decode (
   input  utt_pkg::state_type           cur,
   input  utt_pkg::req_type             item,
   input  logic [15:0]                  unit_capacity,
   input  logic [15:0]                  replacement_code,
   output utt_pkg::state_type           nxt,
   output utt_pkg::rsp_type [2:0]       res,
   output logic [1:0]                   nres
);
   import utt_pkg::*;

   logic [7:0]  b;
   logic        eos;
   logic        full1;
   logic        full2;
   logic [20:0] acc_shift;
   logic        fin;
   logic [20:0] cp;
   logic [2:0]  flen;
   logic [20:0] cpx;
   logic        need2;
   logic [19:0] v;
   logic        do_halt;
   stop_type    halt_r;
   logic [1:0]  nd;
   logic [15:0] u0;
   logic [15:0] u1;
   logic [20:0] repl_x;

   assign b         = item.in_byte;
   assign eos       = item.end_of_string;
   assign repl_x    = {5'd0, replacement_code};
   assign acc_shift = {cur.acc[14:0], b[5:0]};
   assign full1     = cur.count >= unit_capacity;
   assign full2     = ({1'b0, cur.count} + 17'd1) >= {1'b0, unit_capacity};

   always_comb begin
      nxt     = cur;
      fin     = 1'b0;
      cp      = '0;
      flen    = '0;
      cpx     = '0;
      need2   = 1'b0;
      v       = '0;
      do_halt = 1'b0;
      halt_r  = STOP_COMPLETE;
      nd      = 2'd0;
      u0      = '0;
      u1      = '0;

      if (!cur.halted) begin
         if (cur.remaining == 2'd0) begin
            if (full1) begin
               do_halt = 1'b1;
               halt_r  = STOP_FULL;
            end else if (b == 8'd0) begin
               do_halt = 1'b1;
               halt_r  = STOP_NUL;
            end else if (b >= BAD_LEAD_MIN) begin
               do_halt = 1'b1;
               halt_r  = STOP_BAD_LEAD;
            end else if (b < ASCII_LIMIT) begin
               fin  = 1'b1;
               cp   = {13'd0, b};
               flen = 3'd1;
            end else if (b < LEAD2_MIN) begin
               // stray continuation byte
               nd = 2'd1;
               u0 = replacement_code;
            end else if (eos) begin
               do_halt = 1'b1;
               halt_r  = STOP_TRUNCATED;
            end else if (b < LEAD3_MIN) begin
               nxt.acc       = {16'd0, b[4:0]};
               nxt.seq_len   = 3'd2;
               nxt.remaining = 2'd1;
            end else if (b < LEAD4_MIN) begin
               nxt.acc       = {17'd0, b[3:0]};
               nxt.seq_len   = 3'd3;
               nxt.remaining = 2'd2;
            end else begin
               nxt.acc       = {18'd0, b[2:0]};
               nxt.seq_len   = 3'd4;
               nxt.remaining = 2'd3;
            end
         end else begin
            nxt.acc       = acc_shift;
            nxt.remaining = cur.remaining - 2'd1;
            if (cur.remaining == 2'd1) begin
               fin  = 1'b1;
               cp   = acc_shift;
               flen = cur.seq_len;
            end else if (eos) begin
               do_halt = 1'b1;
               halt_r  = STOP_TRUNCATED;
            end
         end
      end

      if (fin) begin
         // overlong, surrogate and out-of-range forms get the replacement
         cpx = cp;
         if (cp < CP_2BYTE_MIN) begin
            if (flen > 3'd1) cpx = repl_x;
         end else if (cp < CP_3BYTE_MIN) begin
            if (flen > 3'd2) cpx = repl_x;
         end else if (cp < CP_4BYTE_MIN) begin
            if (flen > 3'd3 || (cp >= SURR_LOW && cp <= SURR_HIGH)) cpx = repl_x;
         end else if (cp > CP_MAX) begin
            cpx = repl_x;
         end
         need2 = cpx >= CP_4BYTE_MIN;
         v     = 20'(cpx - CP_4BYTE_MIN);
         if (need2 ? full2 : full1) begin
            do_halt = 1'b1;
            halt_r  = STOP_FULL;
         end else begin
            if (need2) begin
               nd = 2'd2;
               u0 = HIGH_SURR | {6'd0, v[19:10]};
               u1 = LOW_SURR | {6'd0, v[9:0]};
            end else begin
               nd = 2'd1;
               u0 = cpx[15:0];
            end
            nxt.remaining = 2'd0;
            nxt.seq_len   = 3'd0;
            nxt.acc       = '0;
         end
      end

      if (do_halt) begin
         nxt.halted    = 1'b1;
         nxt.reason    = halt_r;
         nxt.remaining = 2'd0;
         nxt.seq_len   = 3'd0;
         nxt.acc       = '0;
      end

      nxt.count = cur.count + {14'd0, nd};

      for (int k = 0; k < MAX_RES; k++) begin
         if (2'(k) < nd) begin
            res[k].code_unit     = (k == 0) ? u0 : u1;
            res[k].is_end_marker = 1'b0;
            res[k].units_written = cur.count + 16'(k + 1);
            res[k].stop_reason   = STOP_COMPLETE;
         end else begin
            res[k].code_unit     = '0;
            res[k].is_end_marker = 1'b1;
            res[k].units_written = nxt.count;
            res[k].stop_reason   = nxt.halted ? nxt.reason : STOP_COMPLETE;
         end
         res[k].last_of_run = (2'(k) == (nd + {1'b0, eos} - 2'd1));
      end

      // end of string starts a fresh string
      if (eos) begin
         nxt.acc       = '0;
         nxt.remaining = 2'd0;
         nxt.seq_len   = 3'd0;
         nxt.count     = '0;
         nxt.halted    = 1'b0;
         nxt.reason    = STOP_COMPLETE;
      end
   end

   assign nres = nd + {1'b0, eos};

endmodule

// ----- design/utf8_to_utf16_transcoder.sv -----
// utf-8 to utf-16 transcoder top level: input register, decode, result queue, csr
// depends on utt_pkg, utt_decode and utf8_to_utf16_transcoder_defines.svh
//
//  channel | direction | handshake               | transaction
//  req     | in        | req_valid / req_stall   | one utf-8 byte plus end flag
//  rsp     | out       | rsp_valid / rsp_stall   | one utf-16 unit or end marker
//  csr     | in/out    | apb psel/penable/pready | 32-bit register access
//
// a taken byte is held in the input register and decoded there; its results enter the queue together
// the queue drains one result per cycle unless rsp_stall; a byte has zero to three results
// one-result bytes stream at one per cycle unless rsp_stall; the queue depth sets stall slack
// reset clears the string state, the queue and the registers to their defaults
`include "utf8_to_utf16_transcoder_defines.svh"

module utf8_to_utf16_transcoder #(
   parameter int FIFO_ADDR_W = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  utt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output utt_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import utt_pkg::*;

   localparam int DEPTH = 1 << FIFO_ADDR_W;
   localparam int CNT_W = FIFO_ADDR_W + 1;

   logic [15:0] capacity_ff;
   logic [15:0] repl_ff;
   logic        csr_wr;

   logic        item_valid_ff;
   logic        item_valid_in;
   req_type     item_ff;
   logic        accept;
   logic        process;

   state_type   state_ff;
   state_type   state_in;
   rsp_type [2:0] res;
   logic [1:0]  nres;

   rsp_type              fifo_ff [DEPTH];
   logic [FIFO_ADDR_W-1:0] wr_ptr_ff;
   logic [FIFO_ADDR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0]     fifo_count_ff;
   logic [CNT_W-1:0]     fifo_count_in;
   logic [CNT_W-1:0]     after_pop;
   logic                 pop;
   logic [1:0]           push_n;

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;
   assign prdata = (paddr[2] == REG_REPLACEMENT_CODE) ? {16'd0, repl_ff} : {16'd0, capacity_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         repl_ff     <= REPLACEMENT_RESET;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_UNIT_CAPACITY:    capacity_ff <= pwdata[15:0];
            REG_REPLACEMENT_CODE: repl_ff     <= pwdata[15:0];
            default:              ;
         endcase
      end
   end

   // result queue occupancy; a byte is decoded only with room for its worst case
   assign pop       = rsp_valid & ~rsp_stall;
   assign after_pop = fifo_count_ff - CNT_W'(pop);
   assign process   = item_valid_ff && ({1'b0, after_pop} + (CNT_W+1)'(MAX_RES) <=
                                        (CNT_W+1)'(DEPTH));
   assign push_n    = process ? nres : 2'd0;
   assign fifo_count_in = after_pop + CNT_W'(push_n);

   assign req_stall     = item_valid_ff & ~process;
   assign accept        = req_valid & ~req_stall;
   assign item_valid_in = accept | (item_valid_ff & ~process);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   utt_decode u_decode (
      .cur              (state_ff),
      .item             (item_ff),
      .unit_capacity    (capacity_ff),
      .replacement_code (repl_ff),
      .nxt              (state_in),
      .res              (res),
      .nres             (nres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{acc: '0, remaining: '0, seq_len: '0, count: '0, halted: 1'b0,
                       reason: STOP_COMPLETE};
      end else if (process) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RES; k++) begin
         if (2'(k) < push_n) begin
            fifo_ff[wr_ptr_ff + FIFO_ADDR_W'(k)] <= res[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_ff + FIFO_ADDR_W'(push_n);
         rd_ptr_ff     <= rd_ptr_ff + FIFO_ADDR_W'(pop);
         fifo_count_ff <= fifo_count_in;
      end
   end

   assign rsp_valid = fifo_count_ff != '0;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   `UTT_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_count_ff <= CNT_W'(DEPTH), "result queue overflow")
   `UTT_ASSERT_NEXT(a_item_kept, item_valid_ff && !process, item_valid_ff, "stalled byte lost")
   `UTT_ASSERT_NEXT(a_eos_clears, process && item_ff.end_of_string,
                    state_ff.count == 16'd0 && !state_ff.halted, "string state not cleared")
   `UTT_ASSERT_NOW(a_marker_last, rsp_valid && rsp_data.is_end_marker,
                   rsp_data.last_of_run && rsp_data.code_unit == 16'd0, "bad end marker")
   `UTT_ASSERT_NOW(a_data_reason, rsp_valid && !rsp_data.is_end_marker,
                   rsp_data.stop_reason == STOP_COMPLETE, "stop reason on data unit")

endmodule

// ----- bench/tb_utf8_to_utf16_transcoder.sv -----
`timescale 1ns / 1ps
// testbench of utf8_to_utf16_transcoder: utf-8 bytes in, utf-16 units and end markers checked
// depends on utt_pkg and the transcoder rtl; self-checking against its own transcoding predictor
module tb_utf8_to_utf16_transcoder;
   import utt_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   // predicts the units of each accepted byte and holds them until they come back
   class utf16_scoreboard;
      logic [15:0] capacity;
      logic [15:0] replacement;
      logic [20:0] acc;
      logic [1:0]  remaining;
      logic [2:0]  seq_len;
      logic [15:0] count;
      logic        halted;
      stop_type    reason;
      rsp_type     batch[$];
      rsp_type     pending[$];
      int          errors;

      function new();
         capacity    = CAPACITY_RESET;
         replacement = REPLACEMENT_RESET;
         clear_string();
         errors = 0;
      endfunction

      function void clear_string();
         acc       = '0;
         remaining = '0;
         seq_len   = '0;
         count     = '0;
         halted    = 1'b0;
         reason    = STOP_COMPLETE;
      endfunction

      function void set_register(logic idx, logic [15:0] value);
         if (idx == REG_UNIT_CAPACITY) begin
            capacity = value;
         end else begin
            replacement = value;
         end
      endfunction

      function logic [15:0] room();
         return (count >= capacity) ? 16'd0 : capacity - count;
      endfunction

      function void halt_with(stop_type why);
         halted    = 1'b1;
         reason    = why;
         remaining = '0;
         seq_len   = '0;
         acc       = '0;
      endfunction

      function void emit(logic [15:0] unit);
         rsp_type r;
         count           = count + 16'd1;
         r.code_unit     = unit;
         r.is_end_marker = 1'b0;
         r.units_written = count;
         r.stop_reason   = STOP_COMPLETE;
         r.last_of_run   = 1'b0;
         batch.push_back(r);
      endfunction

      function void finish_point(logic [20:0] cp, logic [2:0] len);
         logic [20:0] v;
         int          need;
         if (cp < CP_2BYTE_MIN) begin
            if (len > 3'd1) cp = {5'd0, replacement};
         end else if (cp < CP_3BYTE_MIN) begin
            if (len > 3'd2) cp = {5'd0, replacement};
         end else if (cp < CP_4BYTE_MIN) begin
            if (len > 3'd3 || (cp >= SURR_LOW && cp <= SURR_HIGH)) cp = {5'd0, replacement};
         end else if (cp > CP_MAX) begin
            cp = {5'd0, replacement};
         end
         need = (cp >= CP_4BYTE_MIN) ? 2 : 1;
         if (need > room()) begin
            halt_with(STOP_FULL);
            return;
         end
         if (need == 2) begin
            v = cp - CP_4BYTE_MIN;
            emit(HIGH_SURR | {6'd0, v[19:10]});
            emit(LOW_SURR | {6'd0, v[9:0]});
         end else begin
            emit(cp[15:0]);
         end
         remaining = '0;
         seq_len   = '0;
         acc       = '0;
      endfunction

      function void note_byte(req_type item);
         logic [7:0]  b;
         logic        eos;
         logic [2:0]  len;
         logic [20:0] lead;
         rsp_type     mark;
         b   = item.in_byte;
         eos = item.end_of_string;
         batch.delete();
         if (!halted) begin
            if (remaining == 2'd0) begin
               // capacity is checked before the byte is even looked at
               if (room() == 16'd0) begin
                  halt_with(STOP_FULL);
               end else if (b == 8'd0) begin
                  halt_with(STOP_NUL);
               end else if (b >= BAD_LEAD_MIN) begin
                  halt_with(STOP_BAD_LEAD);
               end else if (b < ASCII_LIMIT) begin
                  finish_point({13'd0, b}, 3'd1);
               end else if (b < LEAD2_MIN) begin
                  emit(replacement);
               end else begin
                  if (b < LEAD3_MIN) begin
                     len  = 3'd2;
                     lead = {16'd0, b[4:0]};
                  end else if (b < LEAD4_MIN) begin
                     len  = 3'd3;
                     lead = {17'd0, b[3:0]};
                  end else begin
                     len  = 3'd4;
                     lead = {18'd0, b[2:0]};
                  end
                  if (eos) begin
                     halt_with(STOP_TRUNCATED);
                  end else begin
                     acc       = lead;
                     seq_len   = len;
                     remaining = 2'(len - 3'd1);
                  end
               end
            end else begin
               // continuation prefix is not checked
               acc       = {acc[14:0], b[5:0]};
               remaining = remaining - 2'd1;
               if (remaining == 2'd0) begin
                  finish_point(acc, seq_len);
               end else if (eos) begin
                  halt_with(STOP_TRUNCATED);
               end
            end
         end
         if (eos) begin
            mark.code_unit     = '0;
            mark.is_end_marker = 1'b1;
            mark.units_written = count;
            mark.stop_reason   = halted ? reason : STOP_COMPLETE;
            mark.last_of_run   = 1'b0;
            batch.push_back(mark);
            clear_string();
         end
         if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
         foreach (batch[i]) pending.push_back(batch[i]);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_unit(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing expected, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("code_unit", want.code_unit, got.code_unit);
         compare_field("is_end_marker", {15'd0, want.is_end_marker}, {15'd0, got.is_end_marker});
         compare_field("units_written", want.units_written, got.units_written);
         compare_field("stop_reason", {13'd0, want.stop_reason}, {13'd0, got.stop_reason});
         compare_field("last_of_run", {15'd0, want.last_of_run}, {15'd0, got.last_of_run});
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   utf16_scoreboard sb;
   bit              idling_on;
   int              stall_left;
   int              cycles;
   req_type         stream[$];

   utf8_to_utf16_transcoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_unit(rsp_data);
   end

   // receiver stalls in bursts
   initial begin
      forever begin
         @(negedge clock);
         if (idling_on && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 9);
         if (idling_on && stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left = 0;
         end
      end
   end

   function automatic void push_byte(ref req_type q[$], input logic [7:0] b, input logic eos);
      req_type item;
      item.in_byte       = b;
      item.end_of_string = eos;
      q.push_back(item);
   endfunction

   // encodes cp in len bytes and keeps the first keep of them
   function automatic void push_point(ref req_type q[$], input logic [20:0] cp, input int len,
                                      input int keep, input bit loose);
      logic [7:0] enc[4];
      enc[0] = {1'b0, cp[6:0]};
      enc[1] = {2'b10, cp[5:0]};
      enc[2] = {2'b10, cp[5:0]};
      enc[3] = {2'b10, cp[5:0]};
      if (len == 2) begin
         enc[0] = {3'b110, cp[10:6]};
      end else if (len == 3) begin
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
      end else if (len == 4) begin
         enc[0] = {5'b11110, cp[20:18]};
         enc[1] = {2'b10, cp[17:12]};
         enc[2] = {2'b10, cp[11:6]};
      end
      for (int i = 1; i < len; i++)
         if (loose) enc[i][7:6] = 2'($urandom_range(0, 3));
      for (int i = 0; i < keep; i++) push_byte(q, enc[i], 1'b0);
   endfunction

   function automatic void add_string(ref req_type q[$], input int maxp);
      int      points;
      int      sel;
      int      len;
      int      lim;
      req_type tail;
      points = $urandom_range(1, maxp);
      for (int p = 0; p < points; p++) begin
         sel = $urandom_range(0, 19);
         if (sel < 6) begin
            push_point(q, 21'($urandom_range(1, 127)), 1, 1, 0);
         end else if (sel < 9) begin
            push_point(q, 21'($urandom_range(CP_2BYTE_MIN, CP_3BYTE_MIN - 1)), 2, 2, 0);
         end else if (sel < 12) begin
            push_point(q, 21'($urandom_range(CP_3BYTE_MIN, CP_4BYTE_MIN - 1)), 3, 3, 0);
         end else if (sel < 14) begin
            push_point(q, 21'($urandom_range(CP_4BYTE_MIN, CP_MAX)), 4, 4, 0);
         end else if (sel == 14) begin
            // overlong form
            len = $urandom_range(2, 4);
            lim = (len == 2) ? int'(CP_2BYTE_MIN) : (len == 3) ? int'(CP_3BYTE_MIN) :
                  int'(CP_4BYTE_MIN);
            push_point(q, 21'($urandom_range(0, lim - 1)), len, len, 0);
         end else if (sel == 15) begin
            if ($urandom_range(0, 1) == 0)
               push_point(q, 21'($urandom_range(SURR_LOW, SURR_HIGH)), 3, 3, 0);
            else
               push_point(q, 21'($urandom_range(CP_MAX + 1, 21'h1FFFFF)), 4, 4, 0);
         end else if (sel == 16) begin
            push_byte(q, 8'($urandom_range(ASCII_LIMIT, LEAD2_MIN - 1)), 1'b0);
         end else if (sel == 17) begin
            len = $urandom_range(2, 4);
            push_point(q, 21'($urandom), len, len, 1);
         end else if (sel == 18) begin
            push_byte(q, 8'($urandom_range(0, 255)), 1'b0);
         end else begin
            push_byte(q, ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(BAD_LEAD_MIN, 255)),
                      1'b0);
         end
      end
      // sometimes the string ends inside a sequence
      if ($urandom_range(0, 6) == 0) begin
         len = $urandom_range(2, 4);
         push_point(q, 21'($urandom), len, $urandom_range(1, len - 1), 0);
      end
      tail = q.pop_back();
      tail.end_of_string = 1'b1;
      q.push_back(tail);
   endfunction

   function automatic void build_stream(ref req_type q[$], input int target, input int maxp);
      q.delete();
      while (q.size() < target) add_string(q, maxp);
   endfunction

   task automatic send_bytes(input req_type q[$]);
      foreach (q[i]) begin
         if (idling_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= q[i];
         do @(posedge clock); while (req_stall);
         sb.note_byte(q[i]);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, value);
      @(negedge clock);
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {16'd0, value}) begin
         $display("%0t: register read mismatch, expected %h actual %h", $time,
                  {16'd0, value}, prdata);
         sb.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // lets results and in-flight bytes with no result settle
   task automatic wait_idle();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      idling_on  = 1'b1;
      stall_left = 0;
      cycles     = 0;
      sb         = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings under reset settings
      stream.delete();
      push_byte(stream, 8'h7F, 0); push_byte(stream, 8'h01, 0);
      push_byte(stream, 8'hC2, 0); push_byte(stream, 8'h80, 0);
      push_byte(stream, 8'hC0, 0); push_byte(stream, 8'h80, 0);   // overlong nul
      push_byte(stream, 8'hED, 0); push_byte(stream, 8'hA0, 0);   // surrogate
      push_byte(stream, 8'h80, 0);
      push_byte(stream, 8'hF4, 0); push_byte(stream, 8'h8F, 0);   // top code point, pair
      push_byte(stream, 8'hBF, 0); push_byte(stream, 8'hBF, 0);
      push_byte(stream, 8'hF4, 0); push_byte(stream, 8'h90, 0);   // above the range
      push_byte(stream, 8'h80, 0); push_byte(stream, 8'h80, 0);
      push_byte(stream, 8'hBF, 0);                                 // stray continuation
      push_byte(stream, 8'h41, 1);
      push_byte(stream, 8'h00, 0); push_byte(stream, 8'h41, 1);   // nul halts, rest dropped
      push_byte(stream, 8'hF8, 1);                                 // bad lead
      push_byte(stream, 8'hE2, 0); push_byte(stream, 8'h82, 1);   // cut inside sequence
      push_byte(stream, 8'hC3, 1);                                 // cut on lead
      send_bytes(stream);
      wait_idle();

      build_stream(stream, 64, 10);
      // an open string carried into the next setting
      repeat (6) push_byte(stream, 8'($urandom_range(1, 127)), 1'b0);
      send_bytes(stream);
      wait_idle();

      // tiny capacity, at most the count of the open string
      csr_write(REG_UNIT_CAPACITY, 16'($urandom_range(1, 6)));
      csr_write(REG_REPLACEMENT_CODE, 16'h0000);
      build_stream(stream, 50, 6);
      send_bytes(stream);
      wait_idle();

      csr_write(REG_UNIT_CAPACITY, 16'h0000);
      csr_write(REG_REPLACEMENT_CODE, 16'hFFFF);
      build_stream(stream, 15, 4);
      send_bytes(stream);
      wait_idle();

      // full rate on both sides
      idling_on = 1'b0;
      csr_write(REG_UNIT_CAPACITY, 16'hFFFF);
      csr_write(REG_REPLACEMENT_CODE, 16'($urandom));
      build_stream(stream, 70, 12);
      send_bytes(stream);
      wait_idle();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
